// File: design/stereo_mix_minus_router_assert.svh
// Assertion macros used by the checker module smmr_checker.
`ifndef STEREO_MIX_MINUS_ROUTER_ASSERT_SVH
`define STEREO_MIX_MINUS_ROUTER_ASSERT_SVH

// Same-cycle implication.
`define SMMR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("smmr assertion failed");

// Next-cycle implication.
`define SMMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("smmr assertion failed");

`endif

// File: design/smmr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package smmr_pkg;

  localparam int LANES     = 4;
  localparam int GAIN_BITS = 16;
  localparam int SUM_W     = 48;
  localparam int ROUTE_W   = 3;

  typedef enum logic [ROUTE_W-1:0] {
    ROUTE_MUTE       = 3'd0,
    ROUTE_LEFT       = 3'd1,
    ROUTE_RIGHT      = 3'd2,
    ROUTE_MONO       = 3'd3,
    ROUTE_SEND_LEFT  = 3'd4,
    ROUTE_SEND_RIGHT = 3'd5,
    ROUTE_SEND_MONO  = 3'd6
  } route_e;

  typedef struct packed {
    logic to_sender;
    logic wants_echo;
  } route_ctl_t;

  typedef struct packed {
    logic vld;
    logic fend;
  } ctl_t;

endpackage

`default_nettype wire

// File: design/smmr_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface smmr_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                                             valid;
  logic                                             ready;
  logic signed [SAMPLE_BITS-1:0]                    sample_a;
  logic signed [SAMPLE_BITS-1:0]                    sample_b;
  logic signed [SAMPLE_BITS-1:0]                    sample_c;
  logic signed [SAMPLE_BITS-1:0]                    sample_d;
  logic [smmr_pkg::GAIN_BITS-1:0]                   gain_a;
  logic [smmr_pkg::GAIN_BITS-1:0]                   gain_b;
  logic [smmr_pkg::GAIN_BITS-1:0]                   gain_c;
  logic [smmr_pkg::GAIN_BITS-1:0]                   gain_d;
  logic [smmr_pkg::LANES*smmr_pkg::ROUTE_W-1:0]     lane_routes;
  logic                                             to_sender;
  logic                                             wants_echo;
  logic                                             frame_end;

  modport source (
    output valid, sample_a, sample_b, sample_c, sample_d,
    output gain_a, gain_b, gain_c, gain_d, lane_routes,
    output to_sender, wants_echo, frame_end,
    input  ready
  );

  modport sink (
    input  valid, sample_a, sample_b, sample_c, sample_d,
    input  gain_a, gain_b, gain_c, gain_d, lane_routes,
    input  to_sender, wants_echo, frame_end,
    output ready
  );
endinterface

`default_nettype wire

// File: design/smmr_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface smmr_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;
  logic                          clipped;

  modport source (
    output valid, left_sample, right_sample, clipped,
    input  ready
  );

  modport sink (
    input  valid, left_sample, right_sample, clipped,
    output ready
  );
endinterface

`default_nettype wire

// File: design/stereo_mix_minus_router.sv
// A frame_end item's result passes the lane product, lane sum and accumulated total registers
// and is saturated into the output register, in that order, before it is valid.
// Throughput: one item per cycle; the pipeline holds only while a result waits.
// Reset: asynchronous, active low; clears the left and right accumulators and all valids.
`timescale 1ns / 1ps
`default_nettype none

module stereo_mix_minus_router #(
  parameter int SAMPLE_BITS    = 24,
  parameter int GAIN_FRAC_BITS = 14
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  smmr_in_if.sink   mix_in_i,
  smmr_out_if.source mix_out_o
);

  localparam int PROD_W = SAMPLE_BITS + smmr_pkg::GAIN_BITS;
  localparam int SW     = smmr_pkg::SUM_W;
  localparam int RW     = smmr_pkg::ROUTE_W;
  localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  logic                          en;
  logic                          accept;
  smmr_pkg::route_ctl_t          rctl;
  smmr_pkg::ctl_t                ctl1_d, ctl1_q;
  smmr_pkg::ctl_t                ctl3;
  logic signed [SAMPLE_BITS-1:0] sample [smmr_pkg::LANES];
  logic [smmr_pkg::GAIN_BITS-1:0] gain  [smmr_pkg::LANES];
  logic signed [PROD_W-1:0]      lane_l [smmr_pkg::LANES];
  logic signed [PROD_W-1:0]      lane_r [smmr_pkg::LANES];
  logic signed [SW-1:0]          ltot, rtot;
  logic [SAMPLE_BITS:0]          lsat, rsat;
  logic                          out_vld_d, out_vld_q;
  logic signed [SAMPLE_BITS-1:0] left_q, right_q;
  logic                          clip_q;

  function automatic logic [SAMPLE_BITS:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] sh;
    sh = v >>> GAIN_FRAC_BITS;
    if (sh > SAT_HI) begin
      return {1'b1, SAT_HI[SAMPLE_BITS-1:0]};
    end else if (sh < SAT_LO) begin
      return {1'b1, SAT_LO[SAMPLE_BITS-1:0]};
    end
    return {1'b0, sh[SAMPLE_BITS-1:0]};
  endfunction

  assign en             = !out_vld_q || mix_out_o.ready;
  assign mix_in_i.ready = en;
  assign accept         = mix_in_i.valid && en;

  assign sample[0] = mix_in_i.sample_a;
  assign sample[1] = mix_in_i.sample_b;
  assign sample[2] = mix_in_i.sample_c;
  assign sample[3] = mix_in_i.sample_d;
  assign gain[0]   = mix_in_i.gain_a;
  assign gain[1]   = mix_in_i.gain_b;
  assign gain[2]   = mix_in_i.gain_c;
  assign gain[3]   = mix_in_i.gain_d;

  assign rctl.to_sender  = mix_in_i.to_sender;
  assign rctl.wants_echo = mix_in_i.wants_echo;

  for (genvar l = 0; l < smmr_pkg::LANES; l++) begin : g_lane
    smmr_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .PROD_W      (PROD_W)
    ) u_lane (
      .clk_i    (clk_i),
      .en_i     (en),
      .sample_i (sample[l]),
      .gain_i   (gain[l]),
      .code_i   (mix_in_i.lane_routes[l*RW +: RW]),
      .rctl_i   (rctl),
      .left_o   (lane_l[l]),
      .right_o  (lane_r[l])
    );
  end

  assign ctl1_d.vld  = accept;
  assign ctl1_d.fend = mix_in_i.frame_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
    end else if (en) begin
      ctl1_q <= ctl1_d;
    end
  end

  smmr_merge #(
    .PROD_W (PROD_W)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .ctl_i       (ctl1_q),
    .left_i      (lane_l),
    .right_i     (lane_r),
    .ctl_o       (ctl3),
    .left_tot_o  (ltot),
    .right_tot_o (rtot)
  );

  assign lsat      = sat(ltot);
  assign rsat      = sat(rtot);
  assign out_vld_d = en ? (ctl3.vld && ctl3.fend) : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && ctl3.vld && ctl3.fend) begin
      left_q  <= lsat[SAMPLE_BITS-1:0];
      right_q <= rsat[SAMPLE_BITS-1:0];
      clip_q  <= lsat[SAMPLE_BITS] || rsat[SAMPLE_BITS];
    end
  end

  assign mix_out_o.valid        = out_vld_q;
  assign mix_out_o.left_sample  = left_q;
  assign mix_out_o.right_sample = right_q;
  assign mix_out_o.clipped      = clip_q;

endmodule

`default_nettype wire

// File: design/smmr_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module smmr_lane #(
  parameter int SAMPLE_BITS = 24,
  parameter int PROD_W      = 40
) (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire logic signed [SAMPLE_BITS-1:0]       sample_i,
  input  wire logic [smmr_pkg::GAIN_BITS-1:0]      gain_i,
  input  wire logic [smmr_pkg::ROUTE_W-1:0]        code_i,
  input  wire smmr_pkg::route_ctl_t                rctl_i,
  output logic signed [PROD_W-1:0]                 left_o,
  output logic signed [PROD_W-1:0]                 right_o
);

  localparam int FULL_W = SAMPLE_BITS + smmr_pkg::GAIN_BITS + 1;

  logic signed [FULL_W-1:0] prod_full;
  logic signed [PROD_W-1:0] prod;
  logic                     direct_ok;
  logic                     send_ok;
  logic                     to_l;
  logic                     to_r;
  logic signed [PROD_W-1:0] left_d, left_q;
  logic signed [PROD_W-1:0] right_d, right_q;

  // gain is unsigned: zero-extend before the signed multiply
  assign prod_full = sample_i * $signed({1'b0, gain_i});
  assign prod      = prod_full[PROD_W-1:0];

  assign direct_ok = !rctl_i.to_sender || rctl_i.wants_echo;
  assign send_ok   = !rctl_i.to_sender;

  always_comb begin
    to_l = 1'b0;
    to_r = 1'b0;
    unique case (code_i) inside
      smmr_pkg::ROUTE_LEFT:       to_l = direct_ok;
      smmr_pkg::ROUTE_RIGHT:      to_r = direct_ok;
      smmr_pkg::ROUTE_MONO: begin
        to_l = direct_ok;
        to_r = direct_ok;
      end
      smmr_pkg::ROUTE_SEND_LEFT:  to_l = send_ok;
      smmr_pkg::ROUTE_SEND_RIGHT: to_r = send_ok;
      smmr_pkg::ROUTE_SEND_MONO: begin
        to_l = send_ok;
        to_r = send_ok;
      end
      default: begin
        to_l = 1'b0;
        to_r = 1'b0;
      end
    endcase
  end

  assign left_d  = to_l ? prod : '0;
  assign right_d = to_r ? prod : '0;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign left_o  = left_q;
  assign right_o = right_q;

endmodule

`default_nettype wire

// File: design/smmr_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module smmr_merge #(
  parameter int PROD_W = 40
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire smmr_pkg::ctl_t               ctl_i,
  input  wire logic signed [PROD_W-1:0]     left_i  [smmr_pkg::LANES],
  input  wire logic signed [PROD_W-1:0]     right_i [smmr_pkg::LANES],
  output smmr_pkg::ctl_t                    ctl_o,
  output logic signed [smmr_pkg::SUM_W-1:0] left_tot_o,
  output logic signed [smmr_pkg::SUM_W-1:0] right_tot_o
);

  localparam int SW = smmr_pkg::SUM_W;

  logic signed [SW-1:0] lsum_d, lsum_q;
  logic signed [SW-1:0] rsum_d, rsum_q;
  smmr_pkg::ctl_t       ctl2_q;
  logic signed [SW-1:0] lacc_d, lacc_q;
  logic signed [SW-1:0] racc_d, racc_q;
  logic signed [SW-1:0] ltot, rtot;
  logic signed [SW-1:0] ltot_q, rtot_q;
  smmr_pkg::ctl_t       ctl3_q;

  // lane reduction, wraps mod 2^SUM_W
  always_comb begin
    lsum_d = '0;
    rsum_d = '0;
    for (int l = 0; l < smmr_pkg::LANES; l++) begin
      lsum_d = lsum_d + SW'(left_i[l]);
      rsum_d = rsum_d + SW'(right_i[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lsum_q <= lsum_d;
      rsum_q <= rsum_d;
    end
  end

  assign ltot = lacc_q + lsum_q;
  assign rtot = racc_q + rsum_q;

  always_comb begin
    lacc_d = lacc_q;
    racc_d = racc_q;
    if (ctl2_q.vld) begin
      lacc_d = ctl2_q.fend ? '0 : ltot;
      racc_d = ctl2_q.fend ? '0 : rtot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
      ctl3_q <= '0;
      lacc_q <= '0;
      racc_q <= '0;
    end else if (en_i) begin
      ctl2_q <= ctl_i;
      ctl3_q <= ctl2_q;
      lacc_q <= lacc_d;
      racc_q <= racc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && ctl2_q.vld && ctl2_q.fend) begin
      ltot_q <= ltot;
      rtot_q <= rtot;
    end
  end

  assign ctl_o       = ctl3_q;
  assign left_tot_o  = ltot_q;
  assign right_tot_o = rtot_q;

endmodule

`default_nettype wire

// File: design/smmr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_mix_minus_router_assert.svh"

module smmr_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_ready_i,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic signed [SAMPLE_BITS-1:0] left_sample_i,
  input wire logic signed [SAMPLE_BITS-1:0] right_sample_i,
  input wire logic                          clipped_i
);

  localparam logic signed [SAMPLE_BITS-1:0] MAX_S = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] MIN_S = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  `SMMR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  `SMMR_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(left_sample_i) && $stable(right_sample_i) && $stable(clipped_i))

  `SMMR_ASSERT_NOW(a_stall_only_on_backpressure, clk_i, rst_ni, !in_ready_i, out_valid_i && !out_ready_i)

  `SMMR_ASSERT_NOW(a_clip_at_rail, clk_i, rst_ni, out_valid_i && clipped_i, left_sample_i == MAX_S || left_sample_i == MIN_S || right_sample_i == MAX_S || right_sample_i == MIN_S)

endmodule

bind stereo_mix_minus_router smmr_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_smmr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (mix_in_i.ready),
  .out_valid_i    (mix_out_o.valid),
  .out_ready_i    (mix_out_o.ready),
  .left_sample_i  (mix_out_o.left_sample),
  .right_sample_i (mix_out_o.right_sample),
  .clipped_i      (mix_out_o.clipped)
);

`default_nettype wire
